[hdl/hed_pkg.sv]
// shared constants, types and the entity name table of the html entity decoder
`timescale 1ns / 1ps

package hed_pkg;

	localparam int MAX_NAME  = 8;
	localparam int NUM_ENT   = 64;
	localparam int NAME_SLOT = 7;
	localparam int NLEN_W    = $clog2(MAX_NAME + 2);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNDEF   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	typedef enum logic [5:0] {
		PH_AMP    = 6'b000001,
		PH_FIRST  = 6'b000010,
		PH_SIGN   = 6'b000100,
		PH_DIGITS = 6'b001000,
		PH_NAME   = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} name_hit_t;

	// names left aligned, first character in the top byte, zero padded
	localparam logic [8*NAME_SLOT-1:0] ENT_TEXT [NUM_ENT] = '{
		{"quot", 24'h0}, {"amp", 32'h0}, {"lt", 40'h0}, {"gt", 40'h0},
		{"Agrave", 8'h0}, {"Aacute", 8'h0}, {"Acirc", 16'h0}, {"Atilde", 8'h0},
		{"Auml", 24'h0}, {"Aring", 16'h0}, {"AElig", 16'h0}, {"Ccedil", 8'h0},
		{"Egrave", 8'h0}, {"Eacute", 8'h0}, {"Ecirc", 16'h0}, {"Euml", 24'h0},
		{"Igrave", 8'h0}, {"Iacute", 8'h0}, {"Icirc", 16'h0}, {"Iuml", 24'h0},
		{"Ntilde", 8'h0}, {"Ograve", 8'h0}, {"Oacute", 8'h0}, {"Ocirc", 16'h0},
		{"Otilde", 8'h0}, {"Ouml", 24'h0}, {"Oslash", 8'h0}, {"Ugrave", 8'h0},
		{"Uacute", 8'h0}, {"Ucirc", 16'h0}, {"Uuml", 24'h0}, {"Yacute", 8'h0},
		{"THORN", 16'h0}, {"szlig", 16'h0}, {"agrave", 8'h0}, {"aacute", 8'h0},
		{"acirc", 16'h0}, {"atilde", 8'h0}, {"auml", 24'h0}, {"aring", 16'h0},
		{"aelig", 16'h0}, {"ccedil", 8'h0}, {"egrave", 8'h0}, {"eacute", 8'h0},
		{"ecirc", 16'h0}, {"euml", 24'h0}, {"igrave", 8'h0}, {"iacute", 8'h0},
		{"icirc", 16'h0}, {"iuml", 24'h0}, {"eth", 32'h0}, {"ntilde", 8'h0},
		{"ograve", 8'h0}, {"oacute", 8'h0}, {"ocirc", 16'h0}, {"otilde", 8'h0},
		{"ouml", 24'h0}, {"oslash", 8'h0}, {"ugrave", 8'h0}, {"uacute", 8'h0},
		{"ucirc", 16'h0}, {"uuml", 24'h0}, {"yacute", 8'h0}, {"thorn", 16'h0}
	};

	localparam logic [7:0] ENT_CODE [NUM_ENT] = '{
		8'd34, 8'd38, 8'd60, 8'd62,
		8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199,
		8'd200, 8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207,
		8'd209, 8'd210, 8'd211, 8'd212, 8'd213, 8'd214, 8'd216, 8'd217,
		8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223, 8'd224, 8'd225,
		8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232, 8'd233,
		8'd234, 8'd235, 8'd236, 8'd237, 8'd238, 8'd239, 8'd240, 8'd241,
		8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd248, 8'd249, 8'd250,
		8'd251, 8'd252, 8'd253, 8'd254
	};

endpackage

[hdl/hed_in_if.sv]
// input byte channel of the html entity decoder
`timescale 1ns / 1ps

interface hed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_string;

	modport source (output valid, output char_byte, output end_of_string, input ready);
	modport sink (input valid, input char_byte, input end_of_string, output ready);
endinterface

[hdl/hed_out_if.sv]
// result channel of the html entity decoder
`timescale 1ns / 1ps

interface hed_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] code;
	logic [1:0]         status;

	modport source (output valid, output code, output status, input ready);
	modport sink (input valid, input code, input status, output ready);
endinterface

[hdl/hed_name_match.sv]
// parallel compare of one name byte against all entity names, and the name lookup
`timescale 1ns / 1ps

module hed_name_match
	import hed_pkg::*;
(
	input  logic [NUM_ENT-1:0] cand,
	input  logic [NLEN_W-1:0]  pos,
	input  logic [7:0]         chr,
	output logic [NUM_ENT-1:0] cand_next,
	output name_hit_t          lookup
);

	logic       in_slot;
	logic [2:0] pos_idx;
	logic       lookup_ok;

	assign in_slot   = pos < NLEN_W'(NAME_SLOT);
	assign pos_idx   = in_slot ? pos[2:0] : 3'd0;
	assign lookup_ok = (pos != '0) && (pos <= NLEN_W'(MAX_NAME)) && in_slot;

	always_comb begin
		cand_next   = '0;
		lookup.hit  = 1'b0;
		lookup.code = '0;
		for (int i = 0; i < NUM_ENT; i++) begin
			cand_next[i] = cand[i] && in_slot &&
				(ENT_TEXT[i][8*(NAME_SLOT-1-pos_idx) +: 8] == chr);
			// names are unique, so at most one entry ends here
			if (cand[i] && lookup_ok && ENT_TEXT[i][8*(NAME_SLOT-1-pos_idx) +: 8] == CH_NUL) begin
				lookup.hit  = 1'b1;
				lookup.code = lookup.code | ENT_CODE[i];
			end
		end
	end

endmodule

[hdl/html_entity_decoder_top.sv]
// top level of the html entity decoder: byte register, parser state and result register
`timescale 1ns / 1ps

// Decodes one HTML character reference per string, fed one byte per beat on
// in_stream; end_of_string marks the last byte. Each string gives exactly one
// beat on out_stream: status ok with the code, undefined for an unknown or
// too long name, or invalid. Bytes stream at one per cycle while the input
// does not wait. A byte is taken into an input register, and from there it
// updates the parser state (a parallel compare against all 64 names, or one
// decimal digit step) and, when it settles the string, writes the result
// register. The input only waits when the result register holds an unread
// result and the registered byte would make another one.
module html_entity_decoder_top
	import hed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hed_in_if.sink    in_stream,
	hed_out_if.source out_stream
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// parser state
	phase_t             phase_q;
	logic [NLEN_W-1:0]  len_q;
	logic [NUM_ENT-1:0] cand_q;
	logic [31:0]        val_q;
	logic               neg_q;
	logic               stop_q;

	// result register
	logic        out_valid_q;
	logic [31:0] code_q;
	logic [1:0]  status_q;

	phase_t             ph_n;
	logic [NLEN_W-1:0]  len_n;
	logic [NUM_ENT-1:0] cand_n;
	logic [31:0]        val_n;
	logic               neg_n;
	logic               stop_n;
	logic               r_vld;
	logic [31:0]        r_code;
	logic [1:0]         r_st;

	logic [NUM_ENT-1:0] cand_step;
	name_hit_t          name_hit;
	logic               advance;
	logic               is_space;
	logic               is_digit;
	logic [7:0]         diff;
	logic [35:0]        prod;
	logic [31:0]        val_step;
	logic [31:0]        num_res;
	logic [NLEN_W-1:0]  len_inc;

	hed_name_match u_match (
		.cand      (cand_q),
		.pos       (len_q),
		.chr       (byte_s1),
		.cand_next (cand_step),
		.lookup    (name_hit)
	);

	// a byte that makes no result never waits on the result register
	assign advance         = valid_s1 && (!r_vld || !out_valid_q || out_stream.ready);
	assign in_stream.ready = !valid_s1 || advance;

	assign is_space = (byte_s1 == CH_SPACE) || (byte_s1 inside {[CH_TAB:CH_CR]});
	assign is_digit = byte_s1 inside {[CH_0:CH_9]};
	assign diff     = byte_s1 - CH_0;

	// value * 10 + digit, saturated at 2^31
	assign prod     = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1) + {32'b0, diff[3:0]};
	assign val_step = (prod > 36'h080000000) ? 32'h80000000 : prod[31:0];

	assign num_res = neg_q ? (32'd0 - val_q) :
		((val_q > 32'h7fffffff) ? 32'h7fffffff : val_q);

	assign len_inc = (len_q <= NLEN_W'(MAX_NAME)) ? len_q + NLEN_W'(1) : len_q;

	always_comb begin
		ph_n   = phase_q;
		len_n  = len_q;
		cand_n = cand_q;
		val_n  = val_q;
		neg_n  = neg_q;
		stop_n = stop_q;
		r_vld  = 1'b0;
		r_code = '0;
		r_st   = ST_OK;
		if (phase_q != PH_DONE) begin
			if (byte_s1 == CH_NUL) begin
				r_vld = 1'b1;
				r_st  = ST_INVALID;
			end else if (phase_q == PH_AMP) begin
				if (byte_s1 != CH_AMP) begin
					r_vld = 1'b1;
					r_st  = ST_INVALID;
				end else begin
					ph_n = PH_FIRST;
				end
			end else if (byte_s1 == CH_SEMI) begin
				r_vld = 1'b1;
				if (phase_q == PH_SIGN || phase_q == PH_DIGITS) begin
					r_code = num_res;
				end else if (phase_q == PH_NAME && name_hit.hit) begin
					r_code = {24'b0, name_hit.code};
				end else begin
					r_st = ST_UNDEF;
				end
			end else if (is_space) begin
				r_vld = 1'b1;
				r_st  = ST_INVALID;
			end else begin
				case (phase_q)
					PH_FIRST: begin
						if (byte_s1 == CH_HASH) begin
							ph_n = PH_SIGN;
						end else begin
							cand_n = cand_step;
							len_n  = len_inc;
							ph_n   = PH_NAME;
						end
					end
					PH_SIGN: begin
						ph_n = PH_DIGITS;
						if (byte_s1 == CH_MINUS) begin
							neg_n = 1'b1;
						end else if (is_digit) begin
							val_n = {28'b0, diff[3:0]};
						end else if (byte_s1 != CH_PLUS) begin
							stop_n = 1'b1;
						end
					end
					PH_DIGITS: begin
						if (!stop_q && is_digit) begin
							val_n = val_step;
						end else begin
							stop_n = 1'b1;
						end
					end
					PH_NAME: begin
						cand_n = cand_step;
						len_n  = len_inc;
					end
					default: begin
						ph_n = phase_q;
					end
				endcase
			end
			if (r_vld) begin
				ph_n = PH_DONE;
			end
		end
		// the last byte always closes the string and rearms the parser
		if (eos_s1) begin
			if (ph_n != PH_DONE) begin
				r_vld  = 1'b1;
				r_code = '0;
				r_st   = ST_INVALID;
			end
			ph_n   = PH_AMP;
			len_n  = '0;
			cand_n = '1;
			val_n  = '0;
			neg_n  = 1'b0;
			stop_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_stream.ready) begin
			valid_s1 <= in_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_stream.valid && in_stream.ready) begin
			byte_s1 <= in_stream.char_byte;
			eos_s1  <= in_stream.end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_AMP;
			len_q   <= '0;
			cand_q  <= '1;
			val_q   <= '0;
			neg_q   <= 1'b0;
			stop_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= ph_n;
			len_q   <= len_n;
			cand_q  <= cand_n;
			val_q   <= val_n;
			neg_q   <= neg_n;
			stop_q  <= stop_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && r_vld) begin
			out_valid_q <= 1'b1;
		end else if (out_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && r_vld) begin
			code_q   <= r_code;
			status_q <= r_st;
		end
	end

	assign out_stream.valid  = out_valid_q;
	assign out_stream.code   = signed'(code_q);
	assign out_stream.status = status_q;

endmodule

[hdl/hed_checker.sv]
// port level checks of the html entity decoder and their bind
`timescale 1ns / 1ps

module hed_checker
	import hed_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [31:0] code,
	input logic [1:0]        status
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code) && $stable(status))
		else $error("result changed while stalled");

	// only ok results carry a code
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> code == 32'sd0)
		else $error("non-ok result with nonzero code");

	// input only waits behind a stalled result
	a_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// no result straight out of reset
	a_reset_idle: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind html_entity_decoder_top hed_checker u_hed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_stream.ready),
	.out_valid (out_stream.valid),
	.out_ready (out_stream.ready),
	.code      (out_stream.code),
	.status    (out_stream.status)
);
